FILE: design/bga_pkg.sv
// ----------------------------------------------------------------------------
// bga_pkg
// Shared types, constants and command/status bundles of the gradient
// accumulator.
// ----------------------------------------------------------------------------
package bga_pkg;

   localparam int IN_SIZE_DEF   = 64;
   localparam int OUT_SIZE_DEF  = 64;
   localparam int MAX_BATCH_DEF = 256;

   localparam int VAL_W   = 16;   // Q3.12 samples
   localparam int PROD_W  = 32;   // Q7.24 products
   localparam int SUM_W   = 48;   // Q23.24 weight sums
   localparam int BIAS_W  = 32;   // Q19.12 bias sums
   localparam int MEAN_W  = 32;
   localparam int BATCH_W = 9;

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_ERROR  = 3'd1;
   localparam logic [2:0] OP_ACTIV  = 3'd2;
   localparam logic [2:0] OP_RD_WGT = 3'd3;
   localparam logic [2:0] OP_RD_BIAS = 3'd4;

   typedef struct packed {
      logic [2:0]              operation;
      logic [5:0]              row_index;
      logic [5:0]              col_index;
      logic signed [VAL_W-1:0] sample_value;
   } bga_req_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] gradient_mean;
      logic                     saturated;
   } bga_rsp_type;

   typedef struct packed {
      logic accept;      // capture the request word
      logic sweep;       // zero one accumulator entry, advance
      logic bias_wr;     // write error element and updated bias sum
      logic act_issue;   // issue one column of the outer product, advance
      logic div_start;   // load divider with the sum just read
      logic rsp_div;     // load result register from the divider
      logic rsp_zero;    // load result register with zero
   } bga_cmd_type;

   typedef struct packed {
      logic row_ok;
      logic col_ok;
      logic sweep_last;
      logic act_last;
      logic pipe_busy;
      logic div_done;
      logic rsp_free;
   } bga_status_type;

endpackage

FILE: design/bga_ram.sv
// ----------------------------------------------------------------------------
// bga_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bga_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/bga_divider.sv
// ----------------------------------------------------------------------------
// bga_divider
// Restoring divider, one quotient bit per cycle: unsigned sum by batch size.
// ----------------------------------------------------------------------------
module bga_divider
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bga_pkg::SUM_W-1:0]      dividend,
   input  logic [bga_pkg::BATCH_W-1:0]    divisor,
   output logic                           busy,
   output logic                           done,
   output logic [bga_pkg::SUM_W-1:0]      quotient
);
   import bga_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   logic [SUM_W-1:0]   dvd_ff, dvd_in;
   logic [BATCH_W-1:0] rem_ff, rem_in;
   logic [BATCH_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [BATCH_W:0]   trial;
   logic               ge;

   always_comb begin
      trial  = {rem_ff, dvd_ff[SUM_W-1]};
      ge     = trial >= {1'b0, div_ff};
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         rem_in = ge ? BATCH_W'(trial - {1'b0, div_ff}) : trial[BATCH_W-1:0];
         dvd_in = {dvd_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dvd_ff;
endmodule

FILE: design/bga_datapath.sv
// ----------------------------------------------------------------------------
// bga_datapath
// Accumulator memories, multiply-accumulate pipeline, mean and result register.
// ----------------------------------------------------------------------------
module bga_datapath #(
   parameter int IN_SIZE   = bga_pkg::IN_SIZE_DEF,
   parameter int OUT_SIZE  = bga_pkg::OUT_SIZE_DEF,
   parameter int MAX_BATCH = bga_pkg::MAX_BATCH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bga_pkg::bga_cmd_type          cmd,
   output bga_pkg::bga_status_type       status,
   input  bga_pkg::bga_req_type          req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bga_pkg::bga_rsp_type          rsp_word,
   input  logic                          csr_wr_en,
   input  logic [bga_pkg::BATCH_W-1:0]   csr_wr_data
);
   import bga_pkg::*;

   localparam int WDEPTH = IN_SIZE * OUT_SIZE;
   localparam int WA = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int BA = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;

   // item registers
   logic signed [VAL_W-1:0] val_ff;
   logic [BA-1:0]           col_ff;
   logic [WA-1:0]           w_addr_ff;
   logic [WA-1:0]           base_ff;
   logic                    bias_op_ff;
   logic [BATCH_W-1:0]      batch_ff;
   logic [WA-1:0]           cnt_ff, cnt_in;

   // multiply-accumulate pipeline
   logic                     v1_ff, v2_ff;
   logic [WA-1:0]            wa1_ff, wa2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]         wd_ff;

   // memories
   logic              w_we;
   logic [WA-1:0]     w_waddr, w_raddr;
   logic [SUM_W-1:0]  w_wdata, w_rdata;
   logic              b_we;
   logic [BIAS_W-1:0] b_wdata, b_rdata;
   logic [BA-1:0]     b_waddr;
   logic [VAL_W-1:0]  e_rdata;

   // mean
   logic [BATCH_W-1:0] divisor;
   logic [SUM_W-1:0]   sum, mag, quot, neg_q;
   logic               neg_ff;
   logic               div_busy, div_done;
   bga_rsp_type        mean;
   logic               rsp_valid_ff;
   bga_rsp_type        rsp_word_ff;
   logic               rsp_free;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         val_ff     <= req_word.sample_value;
         col_ff     <= BA'(req_word.col_index);
         base_ff    <= WA'(32'(req_word.row_index) * OUT_SIZE);
         w_addr_ff  <= WA'(32'(req_word.row_index) * OUT_SIZE + 32'(req_word.col_index));
         bias_op_ff <= (req_word.operation == OP_RD_BIAS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= BATCH_W'(1);
      end else if (csr_wr_en) begin
         batch_ff <= csr_wr_data;
      end
   end

   // shared sweep / column counter
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.accept) begin
         cnt_in = '0;
      end else if (cmd.sweep || cmd.act_issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         v1_ff  <= cmd.act_issue;
         v2_ff  <= v1_ff;
      end
      wa1_ff  <= base_ff + cnt_ff;
      wa2_ff  <= wa1_ff;
      prod_ff <= val_ff * $signed(e_rdata);
      wd_ff   <= w_rdata;
   end

   assign w_raddr = cmd.act_issue ? (base_ff + cnt_ff) : w_addr_ff;
   assign w_we    = cmd.sweep || v2_ff;
   assign w_waddr = cmd.sweep ? cnt_ff : wa2_ff;
   assign w_wdata = cmd.sweep ? '0 : (wd_ff + SUM_W'(prod_ff));

   assign b_we    = (cmd.sweep && (32'(cnt_ff) < 32'(OUT_SIZE))) || cmd.bias_wr;
   assign b_waddr = cmd.sweep ? BA'(cnt_ff) : col_ff;
   assign b_wdata = cmd.sweep ? '0 : (b_rdata + BIAS_W'(val_ff));

   bga_ram #(.WIDTH(SUM_W), .DEPTH(WDEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   bga_ram #(.WIDTH(BIAS_W), .DEPTH(OUT_SIZE)) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (col_ff),
      .rd_data (b_rdata)
   );

   bga_ram #(.WIDTH(VAL_W), .DEPTH(OUT_SIZE)) u_error_ram (
      .clock   (clock),
      .wr_en   (cmd.bias_wr),
      .wr_addr (col_ff),
      .wr_data (val_ff),
      .rd_addr (BA'(cnt_ff)),
      .rd_data (e_rdata)
   );

   // divisor: zero counts as one, clamp to the largest batch
   always_comb begin
      if (batch_ff == '0) begin
         divisor = BATCH_W'(1);
      end else if (32'(batch_ff) > 32'(MAX_BATCH)) begin
         divisor = BATCH_W'(MAX_BATCH);
      end else begin
         divisor = batch_ff;
      end
   end

   assign sum = bias_op_ff ? SUM_W'($signed(b_rdata)) : w_rdata;
   assign mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= sum[SUM_W-1];
      end
   end

   bga_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag),
      .divisor  (divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quot)
   );

   // restore sign, clip to 32 bits
   assign neg_q = ~quot + 1'b1;
   always_comb begin
      if (neg_ff) begin
         mean.saturated     = quot > SUM_W'(64'h8000_0000);
         mean.gradient_mean = mean.saturated ? 32'sh8000_0000 : $signed(neg_q[MEAN_W-1:0]);
      end else begin
         mean.saturated     = quot > SUM_W'(64'h7FFF_FFFF);
         mean.gradient_mean = mean.saturated ? 32'sh7FFF_FFFF : $signed(quot[MEAN_W-1:0]);
      end
   end

   // result register
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_div || cmd.rsp_zero) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_div) begin
         rsp_word_ff <= mean;
      end else if (cmd.rsp_zero) begin
         rsp_word_ff <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      status            = '0;
      status.row_ok     = 32'(req_word.row_index) < 32'(IN_SIZE);
      status.col_ok     = 32'(req_word.col_index) < 32'(OUT_SIZE);
      status.sweep_last = cnt_ff == WA'(WDEPTH - 1);
      status.act_last   = cnt_ff == WA'(OUT_SIZE - 1);
      status.pipe_busy  = v1_ff || v2_ff;
      status.div_done   = div_done;
      status.rsp_free   = rsp_free;
   end

`ifndef NO_ASSERTIONS
   a_sweep_no_mac: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !v1_ff && !v2_ff)
      else $error("clear sweep overlaps multiply-accumulate");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_div || cmd.rsp_zero) |-> rsp_free)
      else $error("result overwritten before taken");
   a_mac_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.act_issue |=> v1_ff ##1 v2_ff)
      else $error("multiply-accumulate pipeline dropped a column");
`endif
endmodule

FILE: design/bga_ctrl.sv
// ----------------------------------------------------------------------------
// bga_ctrl
// Operation sequencer: clear sweep, bias update, outer-product row, mean read.
// ----------------------------------------------------------------------------
module bga_ctrl
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_op,
   input  bga_pkg::bga_status_type  status,
   output bga_pkg::bga_cmd_type     cmd
);
   import bga_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_SWEEP    = 11'b000_0000_0010,
      S_BIAS_RD  = 11'b000_0000_0100,
      S_BIAS_WR  = 11'b000_0000_1000,
      S_ACT      = 11'b000_0001_0000,
      S_DRAIN    = 11'b000_0010_0000,
      S_MEM_RD   = 11'b000_0100_0000,
      S_DIV_LOAD = 11'b000_1000_0000,
      S_DIV      = 11'b001_0000_0000,
      S_OUT      = 11'b010_0000_0000,
      S_ZERO     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               unique case (req_op)
                  OP_CLEAR:   state_in = S_SWEEP;
                  OP_ERROR:   state_in = status.col_ok ? S_BIAS_RD : S_IDLE;
                  OP_ACTIV:   state_in = status.row_ok ? S_ACT : S_IDLE;
                  OP_RD_WGT:  state_in = (status.row_ok && status.col_ok) ? S_MEM_RD : S_ZERO;
                  OP_RD_BIAS: state_in = status.col_ok ? S_MEM_RD : S_ZERO;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_BIAS_RD: state_in = S_BIAS_WR;
         S_BIAS_WR: begin
            cmd.bias_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_ACT: begin
            cmd.act_issue = 1'b1;
            if (status.act_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_IDLE;
            end
         end
         S_MEM_RD: state_in = S_DIV_LOAD;
         S_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.rsp_div = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_ZERO: begin
            if (status.rsp_free) begin
               cmd.rsp_zero = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // reset starts with a full clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_drain_after_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACT && status.act_last) |=> state_ff == S_DRAIN)
      else $error("row did not drain");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !status.pipe_busy)
      else $error("idle with work in flight");
   a_div_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && status.div_done) |=> state_ff == S_OUT)
      else $error("quotient lost");
`endif
endmodule

FILE: design/batch_gradient_accumulator_core.sv
// ----------------------------------------------------------------------------
// batch_gradient_accumulator_core
// Mini-batch weight and bias gradient accumulator for one dense layer.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  operation, row, col, sample
//   rsp      out        rsp_valid/rsp_stall  gradient_mean, saturated
//   csr      in         csr_wr_en            batch_size (9 bits)
//
// Activation word: one weight read-modify-write per column through the weight
//   RAM's single write port, then the multiply-accumulate pipe drains.
// Error word: reads the bias sum, then writes the error element and the new
//   bias sum. Mean read: runs the one-bit-per-cycle divider over the 48-bit
//   sum (48 steps and its done strobe), and waits longer while a held result
//   blocks the output register. Clear: sweeps all IN_SIZE*OUT_SIZE entries.
// After reset the same clearing pass runs with req_stall high; csr writes are
//   taken throughout.
// A finished result waits in the output register; the next word is accepted
//   meanwhile, and only a later result waits for rsp_stall to drop.
// ----------------------------------------------------------------------------
module batch_gradient_accumulator_core #(
   parameter int IN_SIZE   = bga_pkg::IN_SIZE_DEF,
   parameter int OUT_SIZE  = bga_pkg::OUT_SIZE_DEF,
   parameter int MAX_BATCH = bga_pkg::MAX_BATCH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bga_pkg::bga_req_type        req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bga_pkg::bga_rsp_type        rsp_word,
   input  logic                        csr_wr_en,
   input  logic [bga_pkg::BATCH_W-1:0] csr_wr_data
);
   import bga_pkg::*;

   bga_cmd_type    cmd;
   bga_status_type status;

   // sequencer: decodes the operation, steps sweeps and rows
   bga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_word.operation),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, multiply-accumulate pipe, divider and result register
   bga_datapath #(
      .IN_SIZE   (IN_SIZE),
      .OUT_SIZE  (OUT_SIZE),
      .MAX_BATCH (MAX_BATCH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );
endmodule

FILE: verif/tb_batch_gradient_accumulator_core.sv
// ----------------------------------------------------------------------------
// tb_batch_gradient_accumulator_core
// Self-checking bench for the gradient accumulator: a scoreboard class keeps
// its own copy of the weight, bias and error stores and predicts each mean.
// ----------------------------------------------------------------------------
module tb_batch_gradient_accumulator_core;
   import bga_pkg::*;

   localparam int          CYCLE_LIMIT    = 3000000;
   localparam int          ROWS           = IN_SIZE_DEF;
   localparam int          COLS           = OUT_SIZE_DEF;
   localparam int          HOLD_CYCLES    = 3000;
   localparam int          DRAIN_CYCLES   = 4300;  // covers a clear in flight
   localparam int          ITEM_TARGET    = 1300;
   localparam logic [2:0]  OP_UNUSED_LO   = 3'd5;
   localparam logic [2:0]  OP_UNUSED_MID  = 3'd6;
   localparam logic [2:0]  OP_UNUSED_HI   = 3'd7;
   localparam int          REPORT_MAX     = 10;

   // -------------------------------------------------------------------------
   // Gradient predictor and store of expected means
   // -------------------------------------------------------------------------
   class grad_scoreboard;
      logic [SUM_W-1:0]  wgt_sum [ROWS*COLS];
      logic [BIAS_W-1:0] bias_sum [COLS];
      logic [VAL_W-1:0]  err_elem [COLS];
      logic [BATCH_W-1:0] batch_size;
      bga_rsp_type       mean_queue [$];
      int                mismatches;
      int                means_checked;

      function new();
         foreach (wgt_sum[k]) wgt_sum[k] = '0;
         foreach (bias_sum[k]) bias_sum[k] = '0;
         foreach (err_elem[k]) err_elem[k] = '0;
         batch_size    = 1;
         mismatches    = 0;
         means_checked = 0;
      endfunction

      function bga_rsp_type mean_of(longint sum);
         bga_rsp_type r;
         longint      d;
         longint      q;
         d = batch_size;
         if (d == 0) d = 1;
         if (d > MAX_BATCH_DEF) d = MAX_BATCH_DEF;
         q = sum / d;
         r.saturated = 1'b0;
         if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
            r.saturated = 1'b1;
         end else if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
            r.saturated = 1'b1;
         end
         r.gradient_mean = q[31:0];
         return r;
      endfunction

      // Update the stores for one accepted request word.
      function void note_word(bga_req_type w);
         longint      a;
         longint      p;
         longint      s;
         bga_rsp_type r;
         a = longint'(w.sample_value);
         case (w.operation)
            OP_CLEAR: begin
               foreach (wgt_sum[k]) wgt_sum[k] = '0;
               foreach (bias_sum[k]) bias_sum[k] = '0;
            end
            OP_ERROR: begin
               err_elem[w.col_index] = w.sample_value;
               bias_sum[w.col_index] = bias_sum[w.col_index] + BIAS_W'(a);
            end
            OP_ACTIV: begin
               for (int j = 0; j < COLS; j++) begin
                  p = a * longint'($signed(err_elem[j]));
                  wgt_sum[w.row_index*COLS+j] = wgt_sum[w.row_index*COLS+j] + p[SUM_W-1:0];
               end
            end
            OP_RD_WGT: begin
               s = longint'($signed(wgt_sum[w.row_index*COLS+w.col_index]));
               mean_queue.push_back(mean_of(s));
            end
            OP_RD_BIAS: begin
               s = longint'($signed(bias_sum[w.col_index]));
               mean_queue.push_back(mean_of(s));
            end
            default: ;  // unknown codes are dropped
         endcase
      endfunction

      function void check_word(bga_rsp_type got);
         bga_rsp_type want;
         if (mean_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result word: mean %0d sat %0b",
                        got.gradient_mean, got.saturated);
            return;
         end
         want = mean_queue.pop_front();
         means_checked++;
         if (got.gradient_mean !== want.gradient_mean || got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("mean mismatch: expected %0d sat %0b, got %0d sat %0b",
                        want.gradient_mean, want.saturated,
                        got.gradient_mean, got.saturated);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   bga_req_type        req_word    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   bga_rsp_type        rsp_word;
   logic               csr_wr_en   = 1'b0;
   logic [BATCH_W-1:0] csr_wr_data = '0;

   batch_gradient_accumulator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   grad_scoreboard sb = new();

   bit     idle_off       = 1'b0;   // no random gaps on either side
   bit     hold_request   = 1'b0;   // receiver holds off for a long stretch
   bit     err_loaded [COLS];
   int     words_sent     = 0;
   int     activ_sent     = 0;
   int     clears_sent    = 0;
   longint cycle_count    = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Run watchdog: abort if the run exceeds the cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Check every result word taken at this edge against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_word);
   end

   // Receiver: draw a stall length per result; honor a long hold when asked.
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         gap = idle_off ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offer one request word after a random gap; note it once accepted.
   task automatic send_word(logic [2:0] op, logic [5:0] row, logic [5:0] col,
                            logic [VAL_W-1:0] val);
      bga_req_type w;
      int          gap;
      w.operation    = op;
      w.row_index    = row;
      w.col_index    = col;
      w.sample_value = val;
      gap = idle_off ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
      words_sent++;
      if (op == OP_ERROR) err_loaded[col] = 1'b1;
      if (op == OP_ACTIV) activ_sent++;
      if (op == OP_CLEAR) clears_sent++;
   endtask

   // Drop valid, wait for every expected mean, then let a clear finish.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (sb.mean_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_batch_size(logic [BATCH_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.batch_size = v;
   endtask

   // Samples lean on the Q3.12 extremes so products and sums reach saturation.
   function automatic logic [VAL_W-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         default: return VAL_W'($urandom());
      endcase
   endfunction

   // One batch entry: every error element, then a few activations, reads between.
   task automatic batch_entry();
      int n_act;
      for (int j = 0; j < COLS; j++)
         send_word(OP_ERROR, 6'($urandom()), 6'(j), pick_sample());
      n_act = $urandom_range(1, 5);
      for (int k = 0; k < n_act; k++) begin
         send_word(OP_ACTIV, 6'($urandom_range(0, 3)), 6'($urandom()), pick_sample());
         if ($urandom_range(0, 3) == 0)
            send_word(OP_RD_WGT, 6'($urandom_range(0, 3)), 6'($urandom()), '0);
      end
   endtask

   // Random mix: mostly reads, with batch entries, single error and activation words, clears and some noise.
   task automatic random_phase(int budget);
      int stop_at;
      int pick;
      bit all_loaded;
      stop_at = words_sent + budget;
      while (words_sent < stop_at) begin
         all_loaded = 1'b1;
         foreach (err_loaded[j]) all_loaded &= err_loaded[j];
         pick = $urandom_range(0, 99);
         if (pick < 8)
            batch_entry();
         else if (pick < 45)
            send_word(OP_RD_WGT, 6'($urandom_range(0, 3)), 6'($urandom()), VAL_W'($urandom()));
         else if (pick < 60)
            send_word(OP_RD_WGT, 6'($urandom()), 6'($urandom()), VAL_W'($urandom()));
         else if (pick < 75)
            send_word(OP_RD_BIAS, 6'($urandom()), 6'($urandom()), VAL_W'($urandom()));
         else if (pick < 83)
            send_word(OP_ERROR, 6'($urandom()), 6'($urandom()), pick_sample());
         else if (pick < 90 && all_loaded)
            send_word(OP_ACTIV, 6'($urandom()), 6'($urandom()), pick_sample());
         else if (pick < 98)
            send_word(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 6'($urandom()),
                      6'($urandom()), VAL_W'($urandom()));
         else if (pick == 99)
            send_word(OP_CLEAR, 6'($urandom()), 6'($urandom()), VAL_W'($urandom()));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [BATCH_W-1:0] sizes [6];
      foreach (err_loaded[j]) err_loaded[j] = 1'b0;
      sizes[0] = 9'd1;
      sizes[1] = 9'd256;
      sizes[2] = 9'd0;
      sizes[3] = 9'd511;
      sizes[4] = 9'd3;
      sizes[5] = BATCH_W'($urandom_range(2, 255));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // csr writes are taken during the post-reset clearing pass
      write_batch_size(sizes[0]);

      // Directed: extremes, every operation, clear keeps the error store.
      send_word(OP_RD_WGT, 6'd63, 6'd63, 16'h7fff);
      send_word(OP_RD_BIAS, 6'd0, 6'd0, 16'h8000);
      send_word(OP_ERROR, 6'd0, 6'd0, 16'h8000);
      send_word(OP_ERROR, 6'd63, 6'd63, 16'h7fff);
      send_word(OP_ERROR, 6'd0, 6'd0, 16'h8000);
      send_word(OP_RD_BIAS, 6'd0, 6'd0, '0);
      send_word(OP_RD_BIAS, 6'd63, 6'd63, '0);
      send_word(OP_UNUSED_LO, 6'd63, 6'd63, 16'hffff);
      send_word(OP_UNUSED_MID, 6'd0, 6'd0, 16'h0000);
      send_word(OP_UNUSED_HI, 6'd21, 6'd42, 16'h5a5a);
      for (int j = 0; j < COLS; j++)
         send_word(OP_ERROR, 6'd0, 6'(j), 16'h8000);
      // Three extreme products on one row overflow the 32-bit mean.
      repeat (3) send_word(OP_ACTIV, 6'd63, 6'd0, 16'h8000);
      send_word(OP_RD_WGT, 6'd63, 6'd0, '0);
      send_word(OP_ACTIV, 6'd0, 6'd0, 16'h7fff);
      repeat (3) send_word(OP_ACTIV, 6'd1, 6'd0, 16'h7fff);
      send_word(OP_RD_WGT, 6'd1, 6'd63, '0);
      send_word(OP_RD_WGT, 6'd0, 6'd0, '0);
      send_word(OP_CLEAR, 6'd0, 6'd0, '0);
      send_word(OP_RD_WGT, 6'd63, 6'd0, '0);
      send_word(OP_RD_BIAS, 6'd0, 6'd0, '0);
      send_word(OP_ACTIV, 6'd2, 6'd0, 16'h8000);
      send_word(OP_RD_WGT, 6'd2, 6'd5, '0);

      for (int ph = 0; ph < 6; ph++) begin
         drain_block();
         write_batch_size(sizes[ph]);
         idle_off = (ph == 4);
         if (ph == 2) begin
            // Receiver holds off while reads pile up and stall the input.
            hold_request = 1'b1;
            repeat (20) send_word(OP_RD_BIAS, 6'($urandom()), 6'($urandom()), '0);
         end
         random_phase((ITEM_TARGET - 100) / 6);
      end

      drain_block();
      req_valid   <= 1'b0;
      repeat (200) @(posedge clock);

      $display("covered %0d request words (%0d activations, %0d clears), %0d means checked",
               words_sent, activ_sent, clears_sent, sb.means_checked);
      $display("batch sizes 1, 256, 0, 511, 3 and %0d, long receiver hold-off included",
               sizes[5]);
      if (sb.mismatches == 0 && sb.mean_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d means never arrived",
                  sb.mismatches, sb.mean_queue.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: batch_gradient_accumulator_core.f
design/bga_pkg.sv
design/bga_ram.sv
design/bga_divider.sv
design/bga_datapath.sv
design/bga_ctrl.sv
design/batch_gradient_accumulator_core.sv
verif/tb_batch_gradient_accumulator_core.sv
